// ----- src/interval_set_merge_top_assert.svh -----
// Assertion macros used by the checker of the interval set block.
`ifndef INTERVAL_SET_MERGE_TOP_ASSERT_SVH
`define INTERVAL_SET_MERGE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval set check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval set check failed");

`endif

// ----- src/ism_pkg.sv -----
package ism_pkg;

    // Value and total widths are fixed by the item fields
    localparam int VALUE_BITS     = 32;
    localparam int TOTAL_BITS     = VALUE_BITS + 1;
    localparam int MAX_RANGES_DEF = 16;
    localparam int ENTRY_BITS     = 5;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [TOTAL_BITS-1:0] t_total;

    // Command codes
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REPLACE = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        t_value     first_value;
        t_value     last_value;
        t_value     query_value;
    } t_in_item;

    typedef struct packed {
        logic                  hit;
        logic                  status;
        logic [ENTRY_BITS-1:0] entries_used;
        t_total                member_total;
    } t_out_item;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_CLASSIFY,
        OP_INSERT,
        OP_MERGE,
        OP_ABSORB
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_value   lo;
        t_value   hi;
        t_value   q;
    } t_cell_ctl;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic   valid;
        logic   below;   // entry lies wholly below the new range, with a gap
        logic   above;   // entry lies wholly above the new range, with a gap
        logic   ov;      // entry overlaps or touches the new range
        t_value lo;
        t_value hi;
    } t_cell_state;

    // Left of cell 0 looks like an entry below the new range
    localparam t_cell_state CELL_HEAD_EDGE = '{valid: 1'b0, below: 1'b1, above: 1'b0,
                                               ov: 1'b0, lo: '0, hi: '0};
    // Right of the last cell is an empty slot
    localparam t_cell_state CELL_TAIL_EDGE = '{valid: 1'b0, below: 1'b0, above: 1'b0,
                                               ov: 1'b0, lo: '0, hi: '0};

    // a + 1 < b, one bit wider so the top value cannot wrap
    function automatic logic gap_below(input t_value a, input t_value b);
        t_total wa;
        t_total wb;
        wa = {1'b0, a} + TOTAL_BITS'(1);
        wb = {1'b0, b};
        return wa < wb;
    endfunction

endpackage

// ----- src/ism_cell.sv -----
module ism_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ism_pkg::t_cell_ctl   i_ctl,
    input  ism_pkg::t_cell_state i_prev,
    input  ism_pkg::t_cell_state i_next,
    output ism_pkg::t_cell_state o_state,
    output logic                o_match,
    output ism_pkg::t_total      o_delta
);
    import ism_pkg::*;

    t_cell_state r_state;
    t_cell_state n_state;
    t_total      delta;
    logic        head;
    t_value      new_lo;
    t_value      new_hi;

    // First entry of the overlapping run
    assign head   = r_state.ov && !i_prev.ov;
    assign new_lo = (i_ctl.lo < r_state.lo) ? i_ctl.lo : r_state.lo;
    assign new_hi = (i_ctl.hi > r_state.hi) ? i_ctl.hi : r_state.hi;

    // Per-cell update, driven by the broadcast operation
    always_comb begin
        n_state = r_state;
        delta   = '0;
        case (i_ctl.op)
            OP_CLEAR: begin
                n_state.valid = 1'b0;
                n_state.below = 1'b0;
                n_state.above = 1'b0;
                n_state.ov    = 1'b0;
            end
            OP_CLASSIFY: begin
                n_state.below = r_state.valid && gap_below(r_state.hi, i_ctl.lo);
                n_state.above = r_state.valid && gap_below(i_ctl.hi, r_state.lo);
                n_state.ov    = r_state.valid && !n_state.below && !n_state.above;
            end
            OP_INSERT: begin
                // entries above the new range move right by one
                if (i_prev.above) begin
                    n_state = i_prev;
                end else if (i_prev.below && !r_state.below) begin
                    n_state.valid = 1'b1;
                    n_state.below = 1'b0;
                    n_state.above = 1'b0;
                    n_state.ov    = 1'b0;
                    n_state.lo    = i_ctl.lo;
                    n_state.hi    = i_ctl.hi;
                end
            end
            OP_MERGE: begin
                // head swallows its right neighbor, the rest move left
                if (head) begin
                    n_state.hi = i_next.hi;
                    delta      = {1'b0, i_next.lo} - {1'b0, r_state.hi} - TOTAL_BITS'(1);
                end else if (!r_state.below) begin
                    n_state = i_next;
                end
            end
            OP_ABSORB: begin
                if (head) begin
                    n_state.lo = new_lo;
                    n_state.hi = new_hi;
                    delta      = ({1'b0, r_state.lo} - {1'b0, new_lo})
                               + ({1'b0, new_hi} - {1'b0, r_state.hi});
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CELL_TAIL_EDGE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_match = r_state.valid && (r_state.lo <= i_ctl.q) && (i_ctl.q <= r_state.hi);
    assign o_delta = delta;

endmodule

// ----- src/interval_set_merge_top.sv -----
// Channel   Ports                        Handshake
// input     i_item (t_in_item)           taken when start is high and busy is low
// result    o_result (t_out_item)        o_valid high for one cycle, no back-pressure
//
// A query or unused command passes the classify state and shows its result as the
// block turns idle, so the next item can be taken in that same cycle. An insert
// passes the classify state, then the step state; the merge step of the cell chain
// removes one entry per cycle. Synchronous reset empties the table.
// The result side never stalls the block.
module interval_set_merge_top #(
    parameter int MAX_RANGES = ism_pkg::MAX_RANGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ism_pkg::t_in_item  i_item,
    output logic               o_valid,
    output ism_pkg::t_out_item o_result
);
    import ism_pkg::*;

    localparam int CNT_W = $clog2(MAX_RANGES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLASS = 3'b010,
        S_STEP  = 3'b100
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_cmd;
    t_value     r_lo;
    t_value     r_hi;
    t_value     r_q;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_total     r_total;
    t_total     n_total;
    logic       r_valid;
    logic       n_valid;
    t_out_item  r_result;
    t_out_item  n_result;

    t_cell_ctl   ctl;
    t_cell_state cell_state [MAX_RANGES];
    logic [MAX_RANGES-1:0] cell_match;
    t_total      cell_delta [MAX_RANGES];

    logic   accept;
    logic   any_ov;
    logic   merging;
    logic   any_match;
    logic   full;
    t_total delta_sum;
    t_total ins_size;

    assign accept   = start && r_state == S_IDLE;
    assign full     = r_count == CNT_W'(MAX_RANGES);
    assign ins_size = {1'b0, r_hi} - {1'b0, r_lo} + TOTAL_BITS'(1);

    // Chain of cells, each entry next to its neighbors
    for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
        t_cell_state prev_state;
        t_cell_state next_state;
        if (k == 0) begin : g_first
            assign prev_state = CELL_HEAD_EDGE;
        end else begin : g_mid_prev
            assign prev_state = cell_state[k-1];
        end
        if (k == MAX_RANGES - 1) begin : g_last
            assign next_state = CELL_TAIL_EDGE;
        end else begin : g_mid_next
            assign next_state = cell_state[k+1];
        end
        ism_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_prev  (prev_state),
            .i_next  (next_state),
            .o_state (cell_state[k]),
            .o_match (cell_match[k]),
            .o_delta (cell_delta[k])
        );
    end

    // Flags gathered across the chain; only the head cell drives a delta
    always_comb begin
        any_ov    = 1'b0;
        merging   = 1'b0;
        delta_sum = '0;
        for (int k = 0; k < MAX_RANGES; k++) begin
            any_ov    = any_ov | cell_state[k].ov;
            delta_sum = delta_sum | cell_delta[k];
            if (k < MAX_RANGES - 1) begin
                merging = merging | (cell_state[k].ov & cell_state[k+1].ov);
            end
        end
        any_match = |cell_match;
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_valid  = 1'b0;
        n_result = r_result;
        ctl.op   = OP_HOLD;
        ctl.lo   = r_lo;
        ctl.hi   = r_hi;
        ctl.q    = r_q;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CLASS;
                    if (i_item.command == CMD_REPLACE) begin
                        ctl.op  = OP_CLEAR;
                        n_count = '0;
                        n_total = '0;
                    end
                end
            end
            S_CLASS: begin
                ctl.op = OP_CLASSIFY;
                if (r_cmd == CMD_INSERT || r_cmd == CMD_REPLACE) begin
                    n_state = S_STEP;
                end else begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_result.hit          = (r_cmd == CMD_QUERY) && any_match;
                    n_result.status       = 1'b0;
                    n_result.entries_used = ENTRY_BITS'(r_count);
                    n_result.member_total = r_total;
                end
            end
            S_STEP: begin
                n_result.hit    = 1'b0;
                n_result.status = 1'b0;
                if (!any_ov) begin
                    // fresh entry, or reject when the table is full
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    if (full) begin
                        n_result.status = 1'b1;
                    end else begin
                        ctl.op  = OP_INSERT;
                        n_count = r_count + CNT_W'(1);
                        n_total = r_total + ins_size;
                    end
                end else if (merging) begin
                    ctl.op  = OP_MERGE;
                    n_count = r_count - CNT_W'(1);
                    n_total = r_total + delta_sum;
                end else begin
                    ctl.op  = OP_ABSORB;
                    n_total = r_total + delta_sum;
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                end
                n_result.entries_used = ENTRY_BITS'(n_count);
                n_result.member_total = n_total;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    // Item and result payload, bounds put in order on the way in
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_cmd <= i_item.command;
            r_q   <= i_item.query_value;
            if (i_item.first_value < i_item.last_value) begin
                r_lo <= i_item.first_value;
                r_hi <= i_item.last_value;
            end else begin
                r_lo <= i_item.last_value;
                r_hi <= i_item.first_value;
            end
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/ism_checker.sv -----
`include "interval_set_merge_top_assert.svh"

module ism_checker #(
    parameter int MAX_RANGES = ism_pkg::MAX_RANGES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input ism_pkg::t_out_item o_result
);
    import ism_pkg::*;

    // A taken item makes the block busy, with no result shown, in the cycle after
    `ISM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    // One result per item, never two strobes in a row
    `ISM_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    // The block is free again whenever a result is shown
    `ISM_ASSERT_IMP(a_strobe_free, i_clk, i_rst_n, o_valid, !busy)
    // A rejected insert means the table is full
    `ISM_ASSERT_IMP(a_reject_full, i_clk, i_rst_n, o_valid && o_result.status, o_result.entries_used == ENTRY_BITS'(MAX_RANGES))
    // A hit needs a non-empty table and no rejection
    `ISM_ASSERT_IMP(a_hit_members, i_clk, i_rst_n, o_valid && o_result.hit, !o_result.status && o_result.member_total != '0)

endmodule

bind interval_set_merge_top ism_checker #(.MAX_RANGES(MAX_RANGES)) u_ism_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// ----- bench/interval_set_merge_top_tb.sv -----
module interval_set_merge_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ism_pkg::*;

    localparam int         SPAN_SLOTS   = MAX_RANGES_DEF;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         SETTLE_TICKS = 40;
    localparam int         PRINT_CAP    = 60;
    // command code 3 has no name in the package; the block must ignore it
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_item  = '0;
    logic      o_valid;
    t_out_item o_result;

    interval_set_merge_top #(
        .MAX_RANGES(SPAN_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    // Predicted copy of the range table
    t_value      span_lo [SPAN_SLOTS];
    t_value      span_hi [SPAN_SLOTS];
    int          span_count = 0;
    t_out_item   predicted_results[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    t_value      cluster_base = '0;
    int unsigned cluster_spread = 63;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // a + 1 < b, carried one bit wider so the top value cannot wrap
    function automatic bit has_gap(input t_value a, input t_value b);
        return ({1'b0, a} + 33'd1) < {1'b0, b};
    endfunction

    // Insert with coalescing; returns 0 when a new entry is needed and none is free
    function automatic bit merge_span(input t_value a, input t_value b);
        t_value lo;
        t_value hi;
        int     first_idx;
        int     past_idx;
        int     removed;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        first_idx = 0;
        while (first_idx < span_count && has_gap(span_hi[first_idx], lo))
            first_idx++;
        past_idx = first_idx;
        while (past_idx < span_count && !has_gap(hi, span_lo[past_idx]))
            past_idx++;
        // touches nothing: new entry in sorted position
        if (past_idx == first_idx) begin
            if (span_count >= SPAN_SLOTS)
                return 1'b0;
            for (int k = span_count; k > first_idx; k--) begin
                span_lo[k] = span_lo[k-1];
                span_hi[k] = span_hi[k-1];
            end
            span_lo[first_idx] = lo;
            span_hi[first_idx] = hi;
            span_count++;
            return 1'b1;
        end
        // coalesce the touched entries into the first of them
        if (span_lo[first_idx] < lo)
            lo = span_lo[first_idx];
        if (span_hi[past_idx-1] > hi)
            hi = span_hi[past_idx-1];
        span_lo[first_idx] = lo;
        span_hi[first_idx] = hi;
        removed = past_idx - first_idx - 1;
        for (int k = past_idx; k < span_count; k++) begin
            span_lo[k-removed] = span_lo[k];
            span_hi[k-removed] = span_hi[k];
        end
        span_count -= removed;
        return 1'b1;
    endfunction

    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item   r;
        logic [33:0] members;
        r = '0;
        case (it.command)
            CMD_INSERT, CMD_REPLACE: begin
                if (it.command == CMD_REPLACE)
                    span_count = 0;
                r.status = !merge_span(it.first_value, it.last_value);
            end
            CMD_QUERY: begin
                for (int k = 0; k < span_count; k++)
                    if (span_lo[k] <= it.query_value && it.query_value <= span_hi[k])
                        r.hit = 1'b1;
            end
            default: ;
        endcase
        members = '0;
        for (int k = 0; k < span_count; k++)
            members += {2'b00, span_hi[k]} - {2'b00, span_lo[k]} + 34'd1;
        r.entries_used = span_count[ENTRY_BITS-1:0];
        r.member_total = members[TOTAL_BITS-1:0];
        return r;
    endfunction

    function automatic t_in_item make_item(input logic [1:0] cmd, input t_value a,
                                           input t_value b, input t_value q);
        t_in_item it;
        it.command     = cmd;
        it.first_value = a;
        it.last_value  = b;
        it.query_value = q;
        return it;
    endfunction

    // Present one item, idling at random first; start stays high on return
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            i_item <= make_item(CMD_QUERY, $urandom(), $urandom(), $urandom());
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted_results.push_back(apply_command(it));
    endtask

    // Hold the sender off until every result is in
    task automatic drain_results();
        start <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Random values: mostly a moving cluster, some edges, some anywhere
    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 8);
            2:       return $urandom_range(0, 8);
            default: return cluster_base + $urandom_range(0, cluster_spread);
        endcase
    endfunction

    function automatic void move_cluster();
        cluster_base = $urandom();
        case ($urandom_range(0, 2))
            0:       cluster_spread = 63;
            1:       cluster_spread = 1023;
            default: cluster_spread = 65535;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        t_value      lo;
        t_value      len;
        int          k;
        pick = $urandom_range(0, 99);
        it.command = (pick < 55) ? CMD_INSERT :
                     (pick < 91) ? CMD_QUERY  :
                     (pick < 94) ? CMD_REPLACE : CMD_UNUSED;
        if (it.command == CMD_REPLACE)
            move_cluster();
        lo = pick_value();
        case ($urandom_range(0, 9))
            0:       len = $urandom();
            1, 2:    len = $urandom_range(0, cluster_spread / 8);
            default: len = $urandom_range(0, 3);
        endcase
        // a wrapped high end gives reversed bounds as well
        if ($urandom_range(0, 9) < 3) begin
            it.first_value = lo + len;
            it.last_value  = lo;
        end else begin
            it.first_value = lo;
            it.last_value  = lo + len;
        end
        // queries land on and just beside stored bounds half of the time
        if (span_count > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, span_count - 1);
            it.query_value = ($urandom_range(0, 1) ? span_lo[k] : span_hi[k])
                             + $urandom_range(0, 2) - 1;
        end else begin
            it.query_value = (it.command == CMD_QUERY) ? pick_value() : t_value'($urandom());
        end
        return it;
    endfunction

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (predicted_results.size() == 0) begin
                report_mismatch("result with none pending", o_result, '0);
            end else begin
                want = predicted_results.pop_front();
                if (o_result.hit !== want.hit)
                    report_mismatch("hit", o_result.hit, want.hit);
                if (o_result.status !== want.status)
                    report_mismatch("status", o_result.status, want.status);
                if (o_result.entries_used !== want.entries_used)
                    report_mismatch("entries_used", o_result.entries_used,
                                    want.entries_used);
                if (o_result.member_total !== want.member_total)
                    report_mismatch("member_total", o_result.member_total,
                                    want.member_total);
            end
        end
    end

    // Watchdog: cycles with neither an item taken nor a result out
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("interval_set_merge_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Empty table, coalescing, reversed bounds, queries, unused command
    task automatic test_coalesce();
        send_item(make_item(CMD_QUERY,   '0, '0, 32'd0));
        send_item(make_item(CMD_INSERT,  32'd10, 32'd20, '0));
        send_item(make_item(CMD_INSERT,  32'd40, 32'd30, '0));
        send_item(make_item(CMD_INSERT,  32'd21, 32'd21, '0));
        send_item(make_item(CMD_INSERT,  32'd25, 32'd29, '0));
        send_item(make_item(CMD_INSERT,  32'd24, 32'd22, '0));
        send_item(make_item(CMD_QUERY,   '0, '0, 32'd40));
        send_item(make_item(CMD_QUERY,   '0, '0, 32'd41));
        send_item(make_item(CMD_UNUSED,  32'd50, 32'd60, 32'd15));
    endtask

    // Top of the value range must not wrap to zero when testing adjacency
    task automatic test_value_extremes();
        send_item(make_item(CMD_REPLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
        send_item(make_item(CMD_INSERT,  32'd0, 32'd0, '0));
        send_item(make_item(CMD_QUERY,   '0, '0, 32'hFFFF_FFFF));
        send_item(make_item(CMD_INSERT,  32'hFFFF_FFFE, 32'd1, '0));
        send_item(make_item(CMD_QUERY,   '0, '0, 32'h8000_0000));
    endtask

    // Fill all slots, reject a new entry, merge while full, then collapse everything
    task automatic test_table_full();
        send_item(make_item(CMD_REPLACE, 32'd0, 32'd0, '0));
        for (int k = 1; k < SPAN_SLOTS; k++)
            send_item(make_item(CMD_INSERT, t_value'(4 * k), t_value'(4 * k), '0));
        send_item(make_item(CMD_INSERT,  32'd1000, 32'd1000, '0));
        send_item(make_item(CMD_INSERT,  32'd1, 32'd3, '0));
        send_item(make_item(CMD_INSERT,  32'd1000, 32'd1000, '0));
        drain_results();
        send_item(make_item(CMD_INSERT,  32'hFFFF_FFFF, 32'd0, '0));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int count);
        sender_idle_pct = idle_pct;
        move_cluster();
        for (int n = 0; n < count; n++) begin
            send_item(random_item());
            if ($urandom_range(0, 199) == 0)
                drain_results();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 22;
        test_coalesce();
        test_value_extremes();
        test_table_full();
        test_random_traffic(22, 600);
        test_random_traffic(62, 600);
        test_random_traffic(0, 620);

        // let the last results come out, then watch for strays
        start <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (predicted_results.size() != 0)
            report_mismatch("results never produced", predicted_results.size(), 0);
        if (error_count == 0) begin
            $display("interval_set_merge_top_tb: done, clean");
        end else begin
            $display("interval_set_merge_top_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/ism_pkg.sv
src/ism_cell.sv
src/interval_set_merge_top.sv
src/ism_checker.sv
bench/interval_set_merge_top_tb.sv
